// ===== hdl/dtcs_pkg.sv =====
package dtcs_pkg;

  localparam int unsigned DefaultMaxChunk = 65535;

  typedef enum logic [1:0] {
    OP_START_TX     = 2'd0,
    OP_START_RX     = 2'd1,
    OP_START_DUPLEX = 2'd2,
    OP_EVENT        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_CHUNK    = 2'd0,
    OUT_FINISHED = 2'd1,
    OUT_REJECTED = 2'd2,
    OUT_IGNORED  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    MODE_DUPLEX = 2'd0,
    MODE_TX     = 2'd1,
    MODE_RX     = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    TASK_IDLE   = 4'b0001,
    TASK_TX     = 4'b0010,
    TASK_RX     = 4'b0100,
    TASK_DUPLEX = 4'b1000
  } task_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] tx_address;
    logic [31:0] rx_address;
    logic [2:0]  unit_bytes;
    logic [31:0] unit_count;
    logic        repeat_tx;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  port_mode;
    logic [31:0] chunk_tx_address;
    logic [31:0] chunk_rx_address;
    logic [15:0] chunk_units;
    logic [1:0]  frame_code;
    logic        memory_increment;
    logic        busy_res;
  } out_item_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic advance;  // beat moves into the result register this cycle
  } stage_ctl_t;

  function automatic logic [1:0] frame_of(input logic [2:0] unit);
    logic [1:0] code;
    code = 2'd0;
    if (unit == 3'd2) code = 2'd1;
    else if (unit == 3'd4) code = 2'd2;
    return code;
  endfunction

endpackage

// ===== hdl/dtcs_in_reg.sv =====
module dtcs_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtcs_pkg::in_item_t   in_item,
  input  logic                 out_free,
  output dtcs_pkg::stage_ctl_t ctl,
  output dtcs_pkg::in_item_t   item
);
  import dtcs_pkg::*;

  logic held;

  assign ctl.advance = held && out_free;
  assign in_stall    = held && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (ctl.advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/dtcs_core.sv =====
module dtcs_core #(
  parameter int unsigned MAX_CHUNK = dtcs_pkg::DefaultMaxChunk
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dtcs_pkg::stage_ctl_t ctl,
  input  dtcs_pkg::in_item_t   item,
  output dtcs_pkg::out_item_t  result
);
  import dtcs_pkg::*;

  localparam logic [31:0] MaxChunk32 = 32'(MAX_CHUNK);
  localparam logic [15:0] MaxChunk16 = 16'(MAX_CHUNK);

  task_t       current_task, current_task_next;
  logic [31:0] remaining_units, remaining_units_next;
  logic [31:0] next_tx_address, next_tx_address_next;
  logic [31:0] next_rx_address, next_rx_address_next;
  logic [2:0]  saved_unit_bytes, saved_unit_bytes_next;
  logic        repeat_flag, repeat_flag_next;

  logic        is_event, busy, need_tx, need_rx, unit_ok, start_ok, issue;
  task_t       eff_task;
  logic [31:0] eff_rem, eff_tx, eff_rx;
  logic [2:0]  eff_unit;
  logic        eff_rep, tx_used, rx_used, inc;
  logic [15:0] chunk;
  logic [31:0] step;

  always_comb begin
    is_event = (item.operation == OP_EVENT);
    busy     = (current_task != TASK_IDLE);
    need_tx  = (item.operation == OP_START_TX) || (item.operation == OP_START_DUPLEX);
    need_rx  = (item.operation == OP_START_RX) || (item.operation == OP_START_DUPLEX);
    unit_ok  = (item.unit_bytes == 3'd1) || (item.unit_bytes == 3'd2) ||
               (item.unit_bytes == 3'd4);
    start_ok = !is_event && !busy && unit_ok && (item.unit_count != 32'd0) &&
               !(need_tx && item.tx_address == 32'd0) &&
               !(need_rx && item.rx_address == 32'd0);

    // a good start loads its operands; an event works from the saved transfer
    if (start_ok) begin
      unique case (item.operation)
        OP_START_TX: eff_task = TASK_TX;
        OP_START_RX: eff_task = TASK_RX;
        default:     eff_task = TASK_DUPLEX;
      endcase
      eff_rem  = item.unit_count;
      eff_tx   = need_tx ? item.tx_address : 32'd0;
      eff_rx   = need_rx ? item.rx_address : 32'd0;
      eff_unit = item.unit_bytes;
      eff_rep  = (item.operation == OP_START_TX) && item.repeat_tx;
    end else begin
      eff_task = current_task;
      eff_rem  = remaining_units;
      eff_tx   = next_tx_address;
      eff_rx   = next_rx_address;
      eff_unit = saved_unit_bytes;
      eff_rep  = repeat_flag;
    end

    issue   = start_ok || (is_event && busy && remaining_units != 32'd0);
    chunk   = (eff_rem > MaxChunk32) ? MaxChunk16 : eff_rem[15:0];
    // unit size is 1, 2 or 4, so the multiply is a shift by the frame code
    step    = {16'd0, chunk} << frame_of(eff_unit);
    tx_used = (eff_task == TASK_TX) || (eff_task == TASK_DUPLEX);
    rx_used = (eff_task == TASK_RX) || (eff_task == TASK_DUPLEX);
    inc     = !((eff_task == TASK_TX) && eff_rep);

    current_task_next     = current_task;
    remaining_units_next  = remaining_units;
    next_tx_address_next  = next_tx_address;
    next_rx_address_next  = next_rx_address;
    saved_unit_bytes_next = saved_unit_bytes;
    repeat_flag_next      = repeat_flag;
    if (issue) begin
      current_task_next     = eff_task;
      remaining_units_next  = eff_rem - {16'd0, chunk};
      next_tx_address_next  = (tx_used && inc) ? eff_tx + step : eff_tx;
      next_rx_address_next  = rx_used ? eff_rx + step : eff_rx;
      saved_unit_bytes_next = eff_unit;
      repeat_flag_next      = eff_rep;
    end else if (is_event && busy) begin
      current_task_next = TASK_IDLE;
    end

    result = '0;
    result.busy_res = (current_task_next != TASK_IDLE);
    if (issue) begin
      result.outcome = OUT_CHUNK;
      if (eff_task == TASK_TX) result.port_mode = MODE_TX;
      else if (eff_task == TASK_RX) result.port_mode = MODE_RX;
      else result.port_mode = MODE_DUPLEX;
      result.chunk_tx_address = tx_used ? eff_tx : 32'd0;
      result.chunk_rx_address = rx_used ? eff_rx : 32'd0;
      result.chunk_units      = chunk;
      result.frame_code       = frame_of(eff_unit);
      result.memory_increment = inc;
    end else if (!is_event) begin
      result.outcome = OUT_REJECTED;
    end else if (busy) begin
      result.outcome = OUT_FINISHED;
    end else begin
      result.outcome = OUT_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_task     <= TASK_IDLE;
      remaining_units  <= 32'd0;
      next_tx_address  <= 32'd0;
      next_rx_address  <= 32'd0;
      saved_unit_bytes <= 3'd1;
      repeat_flag      <= 1'b0;
    end else if (ctl.advance) begin
      current_task     <= current_task_next;
      remaining_units  <= remaining_units_next;
      next_tx_address  <= next_tx_address_next;
      next_rx_address  <= next_rx_address_next;
      saved_unit_bytes <= saved_unit_bytes_next;
      repeat_flag      <= repeat_flag_next;
    end
  end

endmodule

// ===== hdl/dtcs_out_reg.sv =====
module dtcs_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  dtcs_pkg::stage_ctl_t ctl,
  input  dtcs_pkg::out_item_t  result,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dtcs_pkg::out_item_t  out_item
);
  import dtcs_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_item <= result;
    end
  end

endmodule

// ===== hdl/dma_transfer_chunk_sequencer.sv =====
// Channel  Direction  Handshake            Beat
// in       sink       in_valid, in_stall   operation, addresses, unit size, count, repeat
// out      source     out_valid, out_stall outcome and one chunk descriptor
//
// Every input beat gives exactly one result beat: it is held in the input register, then
// loaded into the result register once the result register is no longer stalled.
// One beat a cycle sustained while the result side is not stalled: input register, one
// pass of compare, shift and 32-bit adds against the transfer state, then the result register.
// rst is synchronous, active high; it returns the sequencer to idle.
// A stalled result holds; the input register still takes one more beat meanwhile.
module dma_transfer_chunk_sequencer #(
  parameter int unsigned MAX_CHUNK = dtcs_pkg::DefaultMaxChunk
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] tx_address,
  input  logic [31:0] rx_address,
  input  logic [2:0]  unit_bytes,
  input  logic [31:0] unit_count,
  input  logic        repeat_tx,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic [1:0]  port_mode,
  output logic [31:0] chunk_tx_address,
  output logic [31:0] chunk_rx_address,
  output logic [15:0] chunk_units,
  output logic [1:0]  frame_code,
  output logic        memory_increment,
  output logic        busy_res
);
  import dtcs_pkg::*;

  in_item_t   in_item, item;
  out_item_t  result, out_item;
  stage_ctl_t ctl;
  logic       out_free;

  assign in_item.operation  = operation;
  assign in_item.tx_address = tx_address;
  assign in_item.rx_address = rx_address;
  assign in_item.unit_bytes = unit_bytes;
  assign in_item.unit_count = unit_count;
  assign in_item.repeat_tx  = repeat_tx;

  dtcs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .ctl      (ctl),
    .item     (item)
  );

  dtcs_core #(.MAX_CHUNK(MAX_CHUNK)) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  dtcs_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign outcome          = out_item.outcome;
  assign port_mode        = out_item.port_mode;
  assign chunk_tx_address = out_item.chunk_tx_address;
  assign chunk_rx_address = out_item.chunk_rx_address;
  assign chunk_units      = out_item.chunk_units;
  assign frame_code       = out_item.frame_code;
  assign memory_increment = out_item.memory_increment;
  assign busy_res         = out_item.busy_res;

  a_chunk_nonempty : assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_CHUNK |-> busy_res && chunk_units != 16'd0)
    else $error("issued chunk without units or busy");

  a_plain_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUT_CHUNK |->
      chunk_units == 16'd0 && port_mode == MODE_DUPLEX && !memory_increment)
    else $error("non-chunk result carries descriptor fields");

  a_idle_after_done : assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_FINISHED || outcome == OUT_IGNORED) |-> !busy_res)
    else $error("busy after finish or ignored event");

  a_stall_needs_held : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule
